@@ hw/rtl/cdhd_pkg.sv @@
// Shared types and constants for the current detector with hysteresis and debounce.
// Used by the channel interfaces, the register bank, the channel slices and the top level.
`default_nettype none

package cdhd_pkg;

    localparam int NUM_CH    = 4;
    localparam int SAMPLE_W  = 10;
    localparam int DELAY_W   = 8;
    localparam int MASK_W    = NUM_CH;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = SAMPLE_W;

    // Hysteresis step and the highest threshold that can still be raised by it.
    localparam logic [SAMPLE_W-1:0] HYST      = 10'd5;
    localparam logic [SAMPLE_W-1:0] HYST_TOP  = 10'd1018;

    localparam logic [MASK_W-1:0]  RST_USE_REF   = 4'hF;
    localparam logic [DELAY_W-1:0] RST_ON_DELAY  = 8'd4;
    localparam logic [DELAY_W-1:0] RST_OFF_DELAY = 8'd25;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] t_sample_vec;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_CH0   = 3'd0,
        CFG_THR_CH1   = 3'd1,
        CFG_THR_CH2   = 3'd2,
        CFG_THR_CH3   = 3'd3,
        CFG_USE_REF   = 3'd4,
        CFG_ON_DELAY  = 3'd5,
        CFG_OFF_DELAY = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [DELAY_W-1:0] on_delay;
        logic [DELAY_W-1:0] off_delay;
    } t_delay;

    typedef struct packed {
        t_sample_vec       threshold;
        logic [MASK_W-1:0] use_ref;
        t_delay            delay;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/cdhd_scan_if.sv @@
// Valid/ready channel carrying one scan word: four sense and four reference readings.
// Depends on cdhd_pkg for the sample width.
`default_nettype none

interface cdhd_scan_if;
    import cdhd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sense_0;
    t_sample sense_1;
    t_sample sense_2;
    t_sample sense_3;
    t_sample reference_0;
    t_sample reference_1;
    t_sample reference_2;
    t_sample reference_3;

    modport source (
        output valid, sense_0, sense_1, sense_2, sense_3,
               reference_0, reference_1, reference_2, reference_3,
        input  ready
    );
    modport sink (
        input  valid, sense_0, sense_1, sense_2, sense_3,
               reference_0, reference_1, reference_2, reference_3,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/cdhd_status_if.sv @@
// Valid/ready channel carrying one status word with the debounced detect bits.
// Depends on cdhd_pkg for the channel count.
`default_nettype none

interface cdhd_status_if;
    import cdhd_pkg::*;

    logic              valid;
    logic              ready;
    logic [NUM_CH-1:0] detect_status;

    modport source (output valid, detect_status, input ready);
    modport sink   (input valid, detect_status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cdhd_cfg.sv @@
// Configuration register bank: fixed thresholds, reference select mask and delays.
// Depends on cdhd_pkg for the register index codes and the t_cfg struct.
`default_nettype none

module cdhd_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cdhd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cdhd_pkg::CFG_DW-1:0]    i_cfg_data,
    output cdhd_pkg::t_cfg                     o_cfg
);
    import cdhd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THR_CH0:   n_cfg.threshold[0]    = i_cfg_data[SAMPLE_W-1:0];
                CFG_THR_CH1:   n_cfg.threshold[1]    = i_cfg_data[SAMPLE_W-1:0];
                CFG_THR_CH2:   n_cfg.threshold[2]    = i_cfg_data[SAMPLE_W-1:0];
                CFG_THR_CH3:   n_cfg.threshold[3]    = i_cfg_data[SAMPLE_W-1:0];
                CFG_USE_REF:   n_cfg.use_ref         = i_cfg_data[MASK_W-1:0];
                CFG_ON_DELAY:  n_cfg.delay.on_delay  = i_cfg_data[DELAY_W-1:0];
                CFG_OFF_DELAY: n_cfg.delay.off_delay = i_cfg_data[DELAY_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold       <= '0;
            r_cfg.use_ref         <= RST_USE_REF;
            r_cfg.delay.on_delay  <= RST_ON_DELAY;
            r_cfg.delay.off_delay <= RST_OFF_DELAY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/cdhd_chan.sv @@
// One detector channel: threshold select, hysteresis, compare and on/off debounce counters.
// Depends on cdhd_pkg for widths, the hysteresis constants and the t_delay struct.
`default_nettype none

module cdhd_chan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic [cdhd_pkg::SAMPLE_W-1:0] i_sense,
    input  wire logic [cdhd_pkg::SAMPLE_W-1:0] i_ref,
    input  wire logic [cdhd_pkg::SAMPLE_W-1:0] i_thr,
    input  wire logic                        i_use_ref,
    input  wire cdhd_pkg::t_delay            i_delay,
    output logic                             o_on,
    output logic                             o_on_next
);
    import cdhd_pkg::*;

    logic               r_on;
    logic [DELAY_W-1:0] r_rise;
    logic [DELAY_W-1:0] r_fall;
    logic               n_on;
    logic [DELAY_W-1:0] n_rise;
    logic [DELAY_W-1:0] n_fall;
    t_sample            w_thr;
    t_sample            w_thr_adj;
    logic               w_above;

    always_comb begin
        w_thr = i_use_ref ? i_ref : i_thr;
        // The threshold moves away from the current state, unless that would leave the range.
        if (r_on) begin
            w_thr_adj = (w_thr >= HYST) ? (w_thr - HYST) : w_thr;
        end else begin
            w_thr_adj = (w_thr <= HYST_TOP) ? (w_thr + HYST) : w_thr;
        end
        w_above = (i_sense > w_thr_adj);

        n_on   = r_on;
        n_rise = r_rise;
        n_fall = r_fall;
        unique case ({r_on, w_above})
            2'b01: begin
                if (r_rise < i_delay.on_delay) begin
                    n_rise = r_rise + 8'd1;
                end else begin
                    n_on   = 1'b1;
                    n_fall = '0;
                end
            end
            2'b00: n_rise = '0;
            2'b11: n_fall = '0;
            2'b10: begin
                if (r_fall < i_delay.off_delay) begin
                    n_fall = r_fall + 8'd1;
                end else begin
                    n_on   = 1'b0;
                    n_rise = '0;
                end
            end
            default: n_on = r_on;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on   <= 1'b0;
            r_rise <= '0;
            r_fall <= '0;
        end else if (i_adv) begin
            r_on   <= n_on;
            r_rise <= n_rise;
            r_fall <= n_fall;
        end
    end

    assign o_on      = r_on;
    assign o_on_next = n_on;

endmodule

`default_nettype wire

@@ hw/rtl/current_detector_hysteresis_debounce.sv @@
// Top level of the four-channel current detector with hysteresis and debounce.
// Depends on cdhd_pkg, cdhd_scan_if, cdhd_status_if, cdhd_cfg and cdhd_chan.
//
//   port       direction  contents
//   i_scan     in         word of four sense and four reference readings
//   o_status   out        word of four debounced detect bits, one per scan
//   i_cfg_*    in         register write: enable, index, data
//
// Each accepted scan word is latched in an input register and then goes through the four
// channel slices into the status register.
// A new word is accepted in every cycle while the status side keeps taking results.
// A stalled status word holds the input register; the input side keeps its ready high
// while that register is free or moving on in the same cycle.
// Synchronous active-low reset clears the detect state, counters and valid flags and
// loads the register defaults (mask 15, on delay 4, off delay 25).
`default_nettype none

module current_detector_hysteresis_debounce (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    cdhd_scan_if.sink                           i_scan,
    cdhd_status_if.source                       o_status,
    input  wire logic                           i_cfg_we,
    input  wire logic [cdhd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cdhd_pkg::CFG_DW-1:0]    i_cfg_data
);
    import cdhd_pkg::*;

    t_cfg              w_cfg;
    logic              r_s1_valid;
    t_sample_vec       r_s1_sense;
    t_sample_vec       r_s1_ref;
    logic              r_out_valid;
    logic [NUM_CH-1:0] r_out_status;
    logic              w_s1_adv;
    logic              w_in_take;
    logic [NUM_CH-1:0] w_on;
    logic [NUM_CH-1:0] w_on_next;

    cdhd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // The input register moves into the status register whenever that slot is free
    // or its word is being taken in this same cycle.
    assign w_s1_adv     = r_s1_valid && (!r_out_valid || o_status.ready);
    assign i_scan.ready = !r_s1_valid || w_s1_adv;
    assign w_in_take    = i_scan.valid && i_scan.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_s1_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_sense <= {i_scan.sense_3, i_scan.sense_2, i_scan.sense_1, i_scan.sense_0};
            r_s1_ref   <= {i_scan.reference_3, i_scan.reference_2,
                           i_scan.reference_1, i_scan.reference_0};
        end
    end

    // The channel slices commit their state exactly when a word moves to the output.
    for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
        cdhd_chan u_chan (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_s1_adv),
            .i_sense   (r_s1_sense[c]),
            .i_ref     (r_s1_ref[c]),
            .i_thr     (w_cfg.threshold[c]),
            .i_use_ref (w_cfg.use_ref[c]),
            .i_delay   (w_cfg.delay),
            .o_on      (w_on[c]),
            .o_on_next (w_on_next[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_status.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_status <= w_on_next;
        end
    end

    assign o_status.valid         = r_out_valid;
    assign o_status.detect_status = r_out_status;

`ifndef SYNTHESIS
    // A pending status word always matches the detect state it was taken from.
    a_status_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status == w_on))
        else $error("status word differs from channel detect state");

    // Detect state changes only when a scan word moves to the output.
    a_state_moves_with_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_adv |=> $stable(w_on))
        else $error("detect state changed without a scan word");

    // A held input word keeps its readings until it moves on.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=>
            (r_s1_valid && $stable(r_s1_sense) && $stable(r_s1_ref)))
        else $error("input register lost a stalled word");
`endif

endmodule

`default_nettype wire

@@ bench/current_detector_hysteresis_debounce_tb.sv @@
// Self-checking testbench for the four-channel current detector with hysteresis and debounce.
// Depends on cdhd_pkg, cdhd_scan_if, cdhd_status_if and the top level of the detector.
`timescale 1ns / 100ps

module current_detector_hysteresis_debounce_tb;
    import cdhd_pkg::*;

    // The run stops here even if the status side stalls forever. The slowest correct run
    // is roughly 1100 scan words plus one long hold, far below this.
    localparam int MAX_CYCLES = 200_000;

    // Index 7 is not a register; a write to it must leave every register alone.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    // One scan word as the testbench sees it. Channel c sits at element [c] of each vector.
    typedef struct packed {
        t_sample_vec sense;
        t_sample_vec refs;
    } t_scan_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DW-1:0]    i_cfg_data;

    cdhd_scan_if   scan_if ();
    cdhd_status_if status_if ();

    current_detector_hysteresis_debounce uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_scan     (scan_if),
        .o_status   (status_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // The testbench's own copy of the register bank.
    t_sample            cfg_threshold [NUM_CH];
    logic [MASK_W-1:0]  cfg_use_ref;
    logic [DELAY_W-1:0] cfg_on_delay;
    logic [DELAY_W-1:0] cfg_off_delay;

    // The testbench's own copy of the debounce state.
    logic [NUM_CH-1:0]  det_state;
    logic [DELAY_W-1:0] rise_cnt [NUM_CH];
    logic [DELAY_W-1:0] fall_cnt [NUM_CH];

    // Status words predicted at scan acceptance, oldest first.
    logic [NUM_CH-1:0] expected_status_q[$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // When set, both sides stop idling. A hold request makes the status side refuse words
    // for a long stretch so that the detector fills up and stalls the scan side.
    bit steady       = 1'b0;
    bit hold_request = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicts the status word for one scan and advances the debounce state. The threshold
    // is moved away from the current state by the hysteresis step, except near the ends of
    // the range, where it is used as it is.
    function automatic logic [NUM_CH-1:0] predict_status(input t_scan_word w);
        t_sample thr;
        logic    on;
        logic    above;
        for (int c = 0; c < NUM_CH; c++) begin
            thr = cfg_use_ref[c] ? w.refs[c] : cfg_threshold[c];
            on  = det_state[c];
            if (on) begin
                if (thr >= HYST) thr = thr - HYST;
            end else if (thr <= HYST_TOP) begin
                thr = thr + HYST;
            end
            above = w.sense[c] > thr;
            if (above && !on) begin
                if (rise_cnt[c] < cfg_on_delay) begin
                    rise_cnt[c]++;
                end else begin
                    det_state[c] = 1'b1;
                    fall_cnt[c]  = '0;
                end
            end else if (above) begin
                fall_cnt[c] = '0;
            end else if (on) begin
                if (fall_cnt[c] < cfg_off_delay) begin
                    fall_cnt[c]++;
                end else begin
                    det_state[c] = 1'b0;
                    rise_cnt[c]  = '0;
                end
            end else begin
                rise_cnt[c] = '0;
            end
        end
        return det_state;
    endfunction

    function automatic t_scan_word mk_scan(input t_sample_vec sense, input t_sample_vec refs);
        t_scan_word w;
        w.sense = sense;
        w.refs  = refs;
        return w;
    endfunction

    // Levels cluster at both ends of the range so that the hysteresis limits are hit often.
    function automatic t_sample pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 12) return t_sample'($urandom_range(4));
        if (r < 24) return t_sample'($urandom_range(1023, 1019));
        return t_sample'($urandom_range(1023));
    endfunction

    // Drives one register write. The write enable is left high so that back-to-back writes
    // never lower and raise it in the same step; finish_writes lowers it afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_THR_CH0:   cfg_threshold[0] = data;
            CFG_THR_CH1:   cfg_threshold[1] = data;
            CFG_THR_CH2:   cfg_threshold[2] = data;
            CFG_THR_CH3:   cfg_threshold[3] = data;
            CFG_USE_REF:   cfg_use_ref      = data[MASK_W-1:0];
            CFG_ON_DELAY:  cfg_on_delay     = data[DELAY_W-1:0];
            CFG_OFF_DELAY: cfg_off_delay    = data[DELAY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic finish_writes();
        i_cfg_we <= 1'b0;
    endtask

    // Offers one scan word, with random idle cycles in front, and predicts its status once
    // the word is taken. Valid stays high on return so that the next word can follow at once.
    task automatic send_scan(input t_scan_word w);
        while (!steady && $urandom_range(99) < 35) begin
            scan_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        scan_if.valid       <= 1'b1;
        scan_if.sense_0     <= w.sense[0];
        scan_if.sense_1     <= w.sense[1];
        scan_if.sense_2     <= w.sense[2];
        scan_if.sense_3     <= w.sense[3];
        scan_if.reference_0 <= w.refs[0];
        scan_if.reference_1 <= w.refs[1];
        scan_if.reference_2 <= w.refs[2];
        scan_if.reference_3 <= w.refs[3];
        do @(posedge i_clk); while (!scan_if.ready);
        expected_status_q.push_back(predict_status(w));
    endtask

    // Stops offering scans and waits until every predicted status word has come out.
    // Each scan yields exactly one status word, so the detector is idle after this.
    task automatic drain();
        scan_if.valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
    endtask

    // Reset defaults: reference thresholds, on delay 4, off delay 25. Full-scale sense over
    // a zero reference turns every channel on at the fifth scan.
    task automatic test_reset_defaults();
        repeat (6) send_scan(mk_scan({4{10'd1023}}, {4{10'd0}}));
        send_scan(mk_scan({4{10'd0}}, {4{10'd1023}}));
        drain();
    endtask

    // Zero delays with fixed thresholds at the range ends. Vectors read {ch3, ch2, ch1, ch0}.
    // Thresholds 0 and 4 cannot be lowered while on, 1019 and 1023 cannot be raised while
    // off. Register data carries stray upper bits, and a write to the unused index follows.
    task automatic test_zero_delay_hysteresis();
        write_reg(CFG_THR_CH0, 10'd0);
        write_reg(CFG_THR_CH1, 10'd4);
        write_reg(CFG_THR_CH2, 10'd1019);
        write_reg(CFG_THR_CH3, 10'd1023);
        write_reg(CFG_USE_REF, 10'h3F0);
        write_reg(CFG_ON_DELAY, 10'h300);
        write_reg(CFG_OFF_DELAY, 10'h200);
        write_reg(CFG_IDX_UNUSED, 10'h3FF);
        finish_writes();
        // Sense equal to the raised threshold is not above it; one more count is.
        send_scan(mk_scan({10'd1023, 10'd1019, 10'd9, 10'd5}, {4{10'h3FF}}));
        send_scan(mk_scan({10'd1023, 10'd1020, 10'd10, 10'd6}, {4{10'h000}}));
        send_scan(mk_scan({10'd0, 10'd1015, 10'd5, 10'd1}, {4{10'h3FF}}));
        send_scan(mk_scan({10'd0, 10'd1014, 10'd4, 10'd0}, {4{10'h000}}));
        send_scan(mk_scan({4{10'd1023}}, {4{10'h3FF}}));
        send_scan(mk_scan({4{10'd0}}, {4{10'h000}}));
        drain();
    endtask

    // Thresholds from the reference readings, including references at both ends.
    task automatic test_reference_threshold();
        write_reg(CFG_USE_REF, 10'h00F);
        write_reg(CFG_ON_DELAY, 10'd2);
        write_reg(CFG_OFF_DELAY, 10'd1);
        finish_writes();
        repeat (3) send_scan(mk_scan({4{10'd1023}}, {4{10'd0}}));
        repeat (2) send_scan(mk_scan({4{10'd0}}, {4{10'd1023}}));
        send_scan(mk_scan({10'd9, 10'd5, 10'd1023, 10'd1023},
                          {10'd4, 10'd0, 10'd1018, 10'd1017}));
        drain();
    endtask

    // Delays changed while counts are partly built up: the kept counts meet the new delays.
    task automatic test_delay_change();
        write_reg(CFG_ON_DELAY, 10'd3);
        write_reg(CFG_OFF_DELAY, 10'd3);
        finish_writes();
        repeat (2) send_scan(mk_scan({4{10'd1023}}, {4{10'd0}}));
        drain();
        write_reg(CFG_ON_DELAY, 10'd1);
        finish_writes();
        send_scan(mk_scan({4{10'd1023}}, {4{10'd0}}));
        repeat (2) send_scan(mk_scan({4{10'd0}}, {4{10'd1023}}));
        drain();
        write_reg(CFG_OFF_DELAY, 10'd0);
        finish_writes();
        send_scan(mk_scan({4{10'd0}}, {4{10'd1023}}));
        drain();
    endtask

    // One random phase. Every register is rewritten first. Each channel then alternates runs
    // of sense clearly above and clearly below its current threshold, so the debounce gets
    // through whole transitions; noise_pct of the readings land near the threshold or
    // anywhere in the range and break runs up.
    task automatic test_random_phase(input int n_items, input int on_d, input int off_d,
                                     input int run_lo, input int run_hi, input int noise_pct);
        int         run_left [NUM_CH];
        logic       bias_above [NUM_CH];
        t_sample    ref_level [NUM_CH];
        t_scan_word w;
        int         base;
        int         r;
        write_reg(CFG_THR_CH0, pick_level());
        write_reg(CFG_THR_CH1, pick_level());
        write_reg(CFG_THR_CH2, pick_level());
        write_reg(CFG_THR_CH3, pick_level());
        write_reg(CFG_USE_REF, CFG_DW'($urandom_range(1023)));
        write_reg(CFG_ON_DELAY, {2'($urandom_range(3)), 8'(on_d)});
        write_reg(CFG_OFF_DELAY, {2'($urandom_range(3)), 8'(off_d)});
        finish_writes();
        for (int c = 0; c < NUM_CH; c++) begin
            run_left[c]   = $urandom_range(run_hi, run_lo);
            bias_above[c] = 1'($urandom_range(1));
            ref_level[c]  = pick_level();
        end
        for (int n = 0; n < n_items; n++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (run_left[c] == 0) begin
                    bias_above[c] = !bias_above[c];
                    run_left[c]   = $urandom_range(run_hi, run_lo);
                end
                run_left[c]--;
                if ($urandom_range(99) < 5) ref_level[c] = pick_level();
                w.refs[c] = ref_level[c];
                base = int'(cfg_use_ref[c] ? ref_level[c] : cfg_threshold[c]);
                r = $urandom_range(99);
                if (r < noise_pct / 3) begin
                    w.sense[c] = pick_level();
                end else if (r < noise_pct) begin
                    w.sense[c] = t_sample'($urandom_range(base + 7 > 1023 ? 1023 : base + 7,
                                                          base < 7 ? 0 : base - 7));
                end else if (bias_above[c]) begin
                    w.sense[c] = t_sample'($urandom_range(1023,
                                                          base + 6 > 1023 ? 1023 : base + 6));
                end else begin
                    w.sense[c] = t_sample'($urandom_range(base < 6 ? 0 : base - 6, 0));
                end
            end
            send_scan(w);
        end
        drain();
    endtask

    // Status side: random stalls, and on request one long hold counted here.
    initial begin
        int hold_left;
        hold_left = 0;
        status_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 100;
            end
            if (hold_left > 0) begin
                hold_left--;
                status_if.ready <= 1'b0;
            end else if (steady) begin
                status_if.ready <= 1'b1;
            end else begin
                status_if.ready <= ($urandom_range(99) >= 35);
            end
        end
    end

    // Every status word taken is compared with the oldest prediction.
    always @(posedge i_clk) begin
        logic [NUM_CH-1:0] want;
        if (i_rst_n && status_if.valid && status_if.ready) begin
            if (expected_status_q.size() == 0) begin
                $display("%0t: status word with none expected, expected none, actual %b",
                         $time, status_if.detect_status);
                mismatch_count++;
            end else begin
                want = expected_status_q.pop_front();
                if (status_if.detect_status !== want) begin
                    $display("%0t: detect_status mismatch, expected %b, actual %b",
                             $time, want, status_if.detect_status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= '0;
        i_cfg_data          <= '0;
        scan_if.valid       <= 1'b0;
        scan_if.sense_0     <= '0;
        scan_if.sense_1     <= '0;
        scan_if.sense_2     <= '0;
        scan_if.sense_3     <= '0;
        scan_if.reference_0 <= '0;
        scan_if.reference_1 <= '0;
        scan_if.reference_2 <= '0;
        scan_if.reference_3 <= '0;

        // The copy of the registers and state starts at the reset values of the detector.
        for (int c = 0; c < NUM_CH; c++) begin
            cfg_threshold[c] = '0;
            rise_cnt[c]      = '0;
            fall_cnt[c]      = '0;
        end
        cfg_use_ref   = RST_USE_REF;
        cfg_on_delay  = RST_ON_DELAY;
        cfg_off_delay = RST_OFF_DELAY;
        det_state     = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_delay_hysteresis();
        test_reference_threshold();
        test_delay_change();

        // Shortest debounce, then each delay at its maximum with runs long enough to cross it.
        test_random_phase(120, 0, 0, 1, 6, 25);
        test_random_phase(300, 255, 0, 260, 280, 0);
        test_random_phase(300, 0, 255, 260, 280, 0);

        // The status side holds off while scan words keep coming.
        hold_request = 1'b1;
        test_random_phase(90, $urandom_range(7), $urandom_range(7), 1, 12, 25);

        steady = 1'b1;
        test_random_phase(90, $urandom_range(7), $urandom_range(7), 1, 12, 25);
        steady = 1'b0;

        test_random_phase(90, $urandom_range(7), $urandom_range(7), 1, 12, 40);
        test_random_phase(90, $urandom_range(7), $urandom_range(7), 2, 20, 15);

        // Waiting here catches any stray status word.
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_status_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cdhd_pkg.sv
hw/rtl/cdhd_scan_if.sv
hw/rtl/cdhd_status_if.sv
hw/rtl/cdhd_cfg.sv
hw/rtl/cdhd_chan.sv
hw/rtl/current_detector_hysteresis_debounce.sv
bench/current_detector_hysteresis_debounce_tb.sv
